FILE: hdl/cfc_pkg.sv
// Shared types and constants of the 3x3 convolution filter.
`default_nettype none
package cfc_pkg;

    // Kernel selection
    typedef enum logic [1:0] {
        MODE_BLUR    = 2'd0,
        MODE_LAPLACE = 2'd1,
        MODE_SHARPEN = 2'd2,
        MODE_ZERO    = 2'd3
    } filt_mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_MAXVAL = 3'd2,
        REG_MODE   = 3'd3,
        REG_COLOR  = 3'd4
    } cfg_reg_t;

    // Window positions that fall outside the image
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } mask_t;

    // Control carried along the pipeline with each transaction
    typedef struct packed {
        logic  emit;
        logic  last;
        mask_t mask;
    } stage_ctl_t;

    localparam int DATA_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int ACC_BITS       = 22;
    // floor(x / 9) == (x * DIV9_MULT) >> DIV9_SHIFT for x < 2**21
    localparam int DIV9_BITS      = 20;
    localparam int DIV9_SHIFT     = 23;
    localparam logic [DIV9_BITS-1:0] DIV9_MULT = 20'd932068;

endpackage
`default_nettype wire

FILE: hdl/cfc_if.sv
// Stream interfaces for pixel input and filtered output.
`default_nettype none
interface cfc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] sample_first;
    logic [15:0] sample_second;
    logic [15:0] sample_third;

    modport source (output valid, action, sample_first, sample_second, sample_third,
                    input ready);
    modport sink   (input valid, action, sample_first, sample_second, sample_third,
                    output ready);
endinterface

interface cfc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_first;
    logic [15:0] result_second;
    logic [15:0] result_third;
    logic        frame_end;

    modport source (output valid, result_first, result_second, result_third, frame_end,
                    input ready);
    modport sink   (input valid, result_first, result_second, result_third, frame_end,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/cfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cfc_cell.sv
// One window cell: holds a pixel and takes its neighbor's pixel on each shift.
`default_nettype none
module cfc_cell #(
    parameter int WIDTH = 48
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pix_reg;

    // Advance the pixel one column on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (shift)
        begin
            pix_reg <= d;
        end
    end

    assign q = pix_reg;

endmodule
`default_nettype wire

FILE: hdl/cfc_lane.sv
// One channel lane: masked neighborhood sums, then kernel result and clamp.
`default_nettype none
module cfc_lane
    import cfc_pkg::*;
#(
    parameter int SB = 16
) (
    input  wire logic             clk,
    input  wire logic             capture,
    input  wire logic [SB-1:0]    win [9],
    input  wire mask_t            mask,
    input  wire filt_mode_t       mode,
    input  wire logic [15:0]      max_value,
    output logic      [15:0]      result
);

    logic [SB-1:0]   mv [9];
    logic [SB+3:0]   sum_next;
    logic [SB+1:0]   edge_next;
    logic [SB+3:0]   sum_reg;
    logic [SB+1:0]   edge_reg;
    logic [SB-1:0]   center_reg;
    logic [SB+DIV9_BITS+3:0]      prod;
    logic signed [ACC_BITS-1:0]   c_ext;
    logic signed [ACC_BITS-1:0]   e_ext;
    logic signed [ACC_BITS-1:0]   lap;
    logic signed [ACC_BITS-1:0]   val;

    // Drop neighbors outside the image and add up the neighborhood
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < 9; i++)
        begin
            mv[i] = win[i];
            if ((i < 3 && mask.top) || (i > 5 && mask.bottom) ||
                (i % 3 == 0 && mask.left) || (i % 3 == 2 && mask.right))
            begin
                mv[i] = '0;
            end
            sum_next = sum_next + (SB+4)'(mv[i]);
        end
        edge_next = (SB+2)'(mv[1]) + (SB+2)'(mv[3]) + (SB+2)'(mv[5]) + (SB+2)'(mv[7]);
    end

    // Hold the sums for the result stage
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            sum_reg    <= sum_next;
            edge_reg   <= edge_next;
            center_reg <= mv[4];
        end
    end

    // Apply the kernel and clamp to [0, max_value]
    always_comb
    begin
        prod  = (SB+DIV9_BITS+4)'(sum_reg) * (SB+DIV9_BITS+4)'(DIV9_MULT);
        c_ext = $signed(ACC_BITS'(center_reg));
        e_ext = $signed(ACC_BITS'(edge_reg));
        lap   = (c_ext <<< 2) - e_ext;
        case (mode)
            MODE_BLUR:    val = $signed(ACC_BITS'(prod[DIV9_SHIFT +: SB+1]));
            MODE_LAPLACE: val = lap;
            MODE_SHARPEN: val = lap + c_ext;
            default:      val = '0;
        endcase
        if (val < 0)
        begin
            result = '0;
        end
        else if (val > $signed(ACC_BITS'(max_value)))
        begin
            result = max_value;
        end
        else
        begin
            result = val[15:0];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/conv3x3_image_filter_core.sv
// Top level of the streaming 3x3 convolution filter.
// Throughput: one transaction per cycle in each direction while the skid stage is empty.
// Order: pixel k's result passes the line-store, window and sum registers to the output
// register or skid after input pixel k + image_width + 1 (or the flush for it) arrives.
// The pipeline is line-store read, window shift, sums, kernel result.
// Reset: counters cleared, registers to defaults, window zeroed; line stores not cleared.
`default_nettype none
module conv3x3_image_filter_core
    import cfc_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [DATA_BITS-1:0]      cfg_data,
    cfc_in_if.sink                         pixel_in,
    cfc_out_if.source                      pixel_out
);

    localparam int SB  = SAMPLE_BITS;
    localparam int PW  = 3 * SB;
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = $clog2(MAX_HEIGHT + 1);

    // Configuration
    logic [WW-1:0]  w_reg;
    logic [HW-1:0]  h_reg;
    logic [15:0]    max_value_reg;
    filt_mode_t     filter_mode_reg;
    logic           color_mode_reg;
    logic           restart;

    // Position counters
    logic [AW-1:0]  in_col_reg;
    logic [RW-1:0]  in_row_reg;
    logic [AW-1:0]  out_col_reg;
    logic [ORW-1:0] out_row_reg;

    // Input stage
    logic           adv;
    logic           accept;
    logic           in_frame;
    logic           act;
    logic           emit;
    logic           last;
    logic           col_wrap;
    logic           ocol_wrap;
    mask_t          mask_next;
    logic [PW-1:0]  bottom_next;

    // Line-store stage
    logic           s1_valid_reg;
    logic           s1_wr_reg;
    logic [AW-1:0]  s1_col_reg;
    logic [PW-1:0]  s1_bottom_reg;
    stage_ctl_t     s1_ctl_reg;
    logic           byp_reg;
    logic [PW-1:0]  byp_top_reg;
    logic [PW-1:0]  byp_mid_reg;
    logic [PW-1:0]  up_rdata;
    logic [PW-1:0]  mid_rdata;
    logic [PW-1:0]  top_eff;
    logic [PW-1:0]  mid_eff;
    logic           shift;
    logic [PW-1:0]  row_in [3];
    logic [PW-1:0]  cell_d [9];
    logic [PW-1:0]  win_q [9];

    // Sum and result stages
    logic           s2_valid_reg;
    stage_ctl_t     s2_ctl_reg;
    logic           s3_valid_reg;
    logic           s3_last_reg;
    logic [SB-1:0]  lane_win [3][9];
    logic [15:0]    lane_res [3];

    // Output register and skid stage
    logic           out_valid_reg;
    logic [15:0]    out_res_reg [3];
    logic           out_last_reg;
    logic           skid_valid_reg;
    logic [15:0]    skid_res_reg [3];
    logic           skid_last_reg;
    logic [15:0]    new_res [3];
    logic           take;

    // Configuration writes; width, height and color restart the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg           <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            h_reg           <= HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
            max_value_reg   <= 16'd255;
            filter_mode_reg <= MODE_BLUR;
            color_mode_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    if (cfg_data[10:0] == 11'd0)
                        w_reg <= WW'(1);
                    else if (32'(cfg_data[10:0]) > MAX_WIDTH)
                        w_reg <= WW'(MAX_WIDTH);
                    else
                        w_reg <= WW'(cfg_data[10:0]);
                end
                REG_HEIGHT:
                begin
                    if (cfg_data[12:0] == 13'd0)
                        h_reg <= HW'(1);
                    else if (32'(cfg_data[12:0]) > MAX_HEIGHT)
                        h_reg <= HW'(MAX_HEIGHT);
                    else
                        h_reg <= HW'(cfg_data[12:0]);
                end
                REG_MAXVAL: max_value_reg   <= cfg_data;
                REG_MODE:   filter_mode_reg <= filt_mode_t'(cfg_data[1:0]);
                REG_COLOR:  color_mode_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign restart = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                                   cfg_index == REG_COLOR);

    // Decide what the incoming transaction does
    assign adv      = !skid_valid_reg;
    assign accept   = pixel_in.valid && adv;
    assign in_frame = 32'(in_row_reg) < 32'(h_reg);
    assign act      = accept && !(pixel_in.action && in_frame);
    assign emit     = (32'(in_row_reg) >= 2) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign col_wrap  = 32'(in_col_reg) + 1 >= 32'(w_reg);
    assign ocol_wrap = 32'(out_col_reg) + 1 >= 32'(w_reg);
    assign last     = emit && ocol_wrap && (32'(out_row_reg) + 1 >= 32'(h_reg));

    always_comb
    begin
        mask_next.top    = out_row_reg == '0;
        mask_next.bottom = 32'(out_row_reg) + 1 >= 32'(h_reg);
        mask_next.left   = out_col_reg == '0;
        mask_next.right  = ocol_wrap;
        bottom_next      = '0;
        if (in_frame)
        begin
            bottom_next[SB-1:0] = pixel_in.sample_first[SB-1:0];
            if (color_mode_reg)
            begin
                bottom_next[2*SB-1:SB] = pixel_in.sample_second[SB-1:0];
                bottom_next[PW-1:2*SB] = pixel_in.sample_third[SB-1:0];
            end
        end
    end

    assign pixel_in.ready = adv;

    // Advance arrival and output positions; clear them at frame end or on a restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (restart || (act && last))
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (act)
        begin
            if (col_wrap)
            begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + RW'(1);
            end
            else
            begin
                in_col_reg <= in_col_reg + AW'(1);
            end
            if (emit)
            begin
                if (ocol_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ORW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + AW'(1);
                end
            end
        end
    end

    // Line stores: read when a transaction is acted on, written from the line-store stage on shift
    cfc_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .clk   (clk),
        .we    (shift && s1_wr_reg),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .re    (act),
        .raddr (in_col_reg),
        .rdata (up_rdata)
    );

    cfc_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .clk   (clk),
        .we    (shift && s1_wr_reg),
        .waddr (s1_col_reg),
        .wdata (s1_bottom_reg),
        .re    (act),
        .raddr (in_col_reg),
        .rdata (mid_rdata)
    );

    // Forward a write that lands on the column read in the same cycle
    assign top_eff = byp_reg ? byp_top_reg : up_rdata;
    assign mid_eff = byp_reg ? byp_mid_reg : mid_rdata;
    assign shift   = adv && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_wr_reg    <= 1'b0;
            s1_ctl_reg   <= '0;
            byp_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_ctl_reg   <= '0;
            s3_valid_reg <= 1'b0;
            s3_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= act;
            if (act)
            begin
                s1_wr_reg      <= in_frame;
                s1_col_reg     <= in_col_reg;
                s1_bottom_reg  <= bottom_next;
                s1_ctl_reg     <= '{emit: emit, last: last, mask: mask_next};
                byp_reg        <= s1_valid_reg && s1_wr_reg && (s1_col_reg == in_col_reg);
                byp_top_reg    <= mid_eff;
                byp_mid_reg    <= s1_bottom_reg;
            end
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
            s2_ctl_reg   <= s1_ctl_reg;
            s3_valid_reg <= s2_valid_reg;
            s3_last_reg  <= s2_ctl_reg.last;
        end
    end

    // Window: three rows of three cells, newest pixel enters on the right
    assign row_in[0] = top_eff;
    assign row_in[1] = mid_eff;
    assign row_in[2] = s1_bottom_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_cell
            if (c == 2)
            begin : g_load
                assign cell_d[r*3 + c] = row_in[r];
            end
            else
            begin : g_pass
                assign cell_d[r*3 + c] = win_q[r*3 + c + 1];
            end
            cfc_cell #(.WIDTH(PW)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d[r*3 + c]),
                .q     (win_q[r*3 + c])
            );
        end
    end

    // One lane per channel
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        for (genvar i = 0; i < 9; i++)
        begin : g_tap
            assign lane_win[ch][i] = win_q[i][ch*SB +: SB];
        end
        cfc_lane #(.SB(SB)) u_lane (
            .clk       (clk),
            .capture   (adv && s2_valid_reg),
            .win       (lane_win[ch]),
            .mask      (s2_ctl_reg.mask),
            .mode      (filter_mode_reg),
            .max_value (max_value_reg),
            .result    (lane_res[ch])
        );
    end

    assign new_res[0] = lane_res[0];
    assign new_res[1] = color_mode_reg ? lane_res[1] : 16'd0;
    assign new_res[2] = color_mode_reg ? lane_res[2] : 16'd0;
    assign take       = out_valid_reg && pixel_out.ready;

    // Output register with skid stage; stall the pipeline while the skid is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_res_reg    <= skid_res_reg;
                out_last_reg   <= skid_last_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (s3_valid_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_res_reg   <= new_res;
                out_last_reg  <= s3_last_reg;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_res_reg   <= new_res;
                skid_last_reg  <= s3_last_reg;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pixel_out.valid         = out_valid_reg;
    assign pixel_out.result_first  = out_res_reg[0];
    assign pixel_out.result_second = out_res_reg[1];
    assign pixel_out.result_third  = out_res_reg[2];
    assign pixel_out.frame_end     = out_last_reg;

    // The skid stage fills only behind a waiting output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while the output register is empty");

    // Arrival column stays inside the configured width
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_col_reg) < 32'(w_reg))
        else $error("arrival column beyond image width");

    // A line-store write to the column being read is always forwarded
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && act && s1_valid_reg && s1_wr_reg && s1_col_reg == in_col_reg) |=> byp_reg)
        else $error("line-store forwarding missed");

endmodule
`default_nettype wire

FILE: bench/tb_conv3x3_image_filter_core.sv
// Self-checking bench for the streaming 3x3 convolution filter core.
`default_nettype none
module tb_conv3x3_image_filter_core
    import cfc_pkg::*;
();

    typedef struct packed {
        logic        action;
        logic [15:0] s0;
        logic [15:0] s1;
        logic [15:0] s2;
    } pixel_item_t;

    typedef struct packed {
        logic [15:0] r0;
        logic [15:0] r1;
        logic [15:0] r2;
        logic        fend;
    } filt_result_t;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 4096;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 20;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DATA_BITS-1:0] cfg_data;

    cfc_in_if  pix_in ();
    cfc_out_if pix_out ();

    conv3x3_image_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (pix_in.sink),
        .pixel_out (pix_out.source)
    );

    // Predictor state
    logic [47:0] upper_row [MAXW];
    logic [47:0] middle_row [MAXW];
    logic [47:0] win [9];
    int unsigned col_in;
    int unsigned row_in;
    int unsigned next_out;
    int unsigned img_w;
    int unsigned img_h;
    int unsigned clamp_max;
    filt_mode_t  kern;
    logic        rgb;

    pixel_item_t  pending_pixels[$];
    filt_result_t expected_pixels[$];

    int errors;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int hold_cycles;
    bit in_fire;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned width_used();
        if (img_w < 1) return 1;
        if (img_w > MAXW) return MAXW;
        return img_w;
    endfunction

    function automatic int unsigned height_used();
        if (img_h < 1) return 1;
        if (img_h > MAXH) return MAXH;
        return img_h;
    endfunction

    function automatic logic [15:0] filter_sample(int ch, int unsigned r, int unsigned c,
                                                  int unsigned w, int unsigned h);
        int acc;
        int coef;
        int dr;
        int dc;
        acc = 0;
        for (dr = 0; dr < 3; dr++)
        begin
            if ((dr == 0 && r == 0) || (dr == 2 && r + 1 >= h)) continue;
            for (dc = 0; dc < 3; dc++)
            begin
                if ((dc == 0 && c == 0) || (dc == 2 && c + 1 >= w)) continue;
                case (kern)
                    MODE_BLUR:    coef = 1;
                    MODE_LAPLACE: coef = (dr == 1 && dc == 1) ? 4 :
                                         ((dr == 1 || dc == 1) ? -1 : 0);
                    MODE_SHARPEN: coef = (dr == 1 && dc == 1) ? 5 :
                                         ((dr == 1 || dc == 1) ? -1 : 0);
                    default:      coef = 0;
                endcase
                acc += int'(win[dr*3+dc][16*ch +: 16]) * coef;
            end
        end
        if (kern == MODE_BLUR) acc = acc / 9;
        if (acc < 0) return 16'd0;
        if (acc > int'(clamp_max)) return clamp_max[15:0];
        return acc[15:0];
    endfunction

    // Advance the predictor by one accepted transaction
    task automatic predict_filter(input pixel_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned arrival;
        int unsigned k;
        logic [47:0] top;
        logic [47:0] mid;
        logic [47:0] bot;
        filt_result_t res;
        w = width_used();
        h = height_used();
        total = w * h;
        arrival = row_in * w + col_in;
        top = '0;
        mid = '0;
        bot = '0;
        if (it.action && arrival < total) return;
        top = upper_row[col_in];
        mid = middle_row[col_in];
        if (arrival < total)
        begin
            bot = {32'd0, it.s0};
            if (rgb) bot = {it.s2, it.s1, it.s0};
            upper_row[col_in] = mid;
            middle_row[col_in] = bot;
        end
        for (int i = 0; i < 3; i++)
        begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
        col_in++;
        if (col_in >= w)
        begin
            col_in = 0;
            row_in++;
        end
        if (arrival < w + 1) return;
        k = next_out;
        res.r0 = filter_sample(0, k / w, k % w, w, h);
        res.r1 = rgb ? filter_sample(1, k / w, k % w, w, h) : 16'd0;
        res.r2 = rgb ? filter_sample(2, k / w, k % w, w, h) : 16'd0;
        res.fend = 1'b0;
        next_out++;
        if (k + 1 >= total)
        begin
            res.fend = 1'b1;
            col_in = 0;
            row_in = 0;
            next_out = 0;
        end
        expected_pixels.push_back(res);
    endtask

    // Record whether the input transaction completed at the last rising edge
    always @(posedge clk)
    begin
        in_fire <= pix_in.valid && pix_in.ready;
    end

    // Driver: feed pending items, idle at random
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
        end
        else
        begin
            if (!pix_in.valid || in_fire)
            begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pix_in.valid         <= 1'b1;
                    pix_in.action        <= pending_pixels[0].action;
                    pix_in.sample_first  <= pending_pixels[0].s0;
                    pix_in.sample_second <= pending_pixels[0].s1;
                    pix_in.sample_third  <= pending_pixels[0].s2;
                    void'(pending_pixels.pop_front());
                end
                else
                begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with an optional long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
        end
        else if (recv_hold)
        begin
            pix_out.ready <= 1'b0;
            if (hold_cycles >= 4000) recv_hold <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
        begin
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
            hold_cycles <= 0;
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        filt_result_t want;
        filt_result_t got;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (pix_in.valid && pix_in.ready)
                predict_filter({pix_in.action, pix_in.sample_first,
                                pix_in.sample_second, pix_in.sample_third});
            if (pix_out.valid && pix_out.ready)
            begin
                got = {pix_out.result_first, pix_out.result_second,
                       pix_out.result_third, pix_out.frame_end};
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.r0 !== want.r0 || got.r1 !== want.r1 ||
                        got.r2 !== want.r2 || got.fend !== want.fend)
                    begin
                        $display("%0t: mismatch, expected %h/%h/%h/%b actual %h/%h/%h/%b",
                                 $time, want.r0, want.r1, want.r2, want.fend,
                                 got.r0, got.r1, got.r2, got.fend);
                        errors++;
                    end
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Write one register while the block is idle
    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WIDTH:  begin img_w = val & 11'h7FF; col_in = 0; row_in = 0; next_out = 0; end
            REG_HEIGHT: begin img_h = val & 13'h1FFF; col_in = 0; row_in = 0; next_out = 0; end
            REG_MAXVAL: clamp_max = val & 16'hFFFF;
            REG_MODE:   kern = filt_mode_t'(val[1:0]);
            default:    begin rgb = val[0]; col_in = 0; row_in = 0; next_out = 0; end
        endcase
    endtask

    // Wait until the queues are empty and the pipeline has settled
    task automatic wait_idle();
        while (pending_pixels.size() > 0 || pix_in.valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Queue one frame, then the flushes that drain it; some noise flushes inside
    task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noise);
        pixel_item_t it;
        for (int p = 0; p < w * h; p++)
        begin
            if (noise && $urandom_range(9) == 0)
            begin
                it = {1'b1, rand_sample(), rand_sample(), rand_sample()};
                pending_pixels.push_back(it);
            end
            it = {1'b0, rand_sample(), rand_sample(), rand_sample()};
            pending_pixels.push_back(it);
        end
        for (int p = 0; p < w + 1; p++)
        begin
            it = {1'($urandom_range(1)), rand_sample(), rand_sample(), rand_sample()};
            pending_pixels.push_back(it);
        end
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned mx, input int unsigned md, input bit c);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MAXVAL, mx);
        write_reg(REG_MODE, md);
        write_reg(REG_COLOR, c);
    endtask

    initial
    begin
        int sent;
        int unsigned w;
        int unsigned h;
        bit wide_done;
        errors = 0;
        cycle_count = 0;
        recv_hold = 0;
        hold_cycles = 0;
        wide_done = 0;
        send_idle_pct = 38;
        recv_idle_pct = 80;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.action = 1'b0;
        pix_in.sample_first = '0;
        pix_in.sample_second = '0;
        pix_in.sample_third = '0;
        pix_out.ready = 1'b0;
        img_w = 1024;
        img_h = 1024;
        clamp_max = 255;
        kern = MODE_BLUR;
        rgb = 1'b0;
        col_in = 0;
        row_in = 0;
        next_out = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every mode on tiny frames, extremes of the clamp
        set_frame(3, 3, 65535, MODE_BLUR, 1);
        queue_frame(3, 3, 0);
        wait_idle();
        for (int md = 1; md < 4; md++)
        begin
            write_reg(REG_MODE, md);
            queue_frame(3, 2, 0);
            wait_idle();
        end
        set_frame(1, 1, 0, MODE_SHARPEN, 0);
        queue_frame(1, 1, 0);
        wait_idle();
        set_frame(2, 1, 1, MODE_LAPLACE, 1);
        queue_frame(2, 1, 0);
        wait_idle();

        // Random frames across three idling phases; one wide frame in the last
        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : ((ph == 1) ? 80 : 0);
            recv_idle_pct = (ph == 0) ? 80 : ((ph == 1) ? 38 : 0);
            while (sent < 340 * (ph + 1))
            begin
                if (ph == 2 && !wide_done)
                begin
                    w = 513;
                    h = 1;
                    wide_done = 1'b1;
                end
                else
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 12);
                end
                set_frame(w, h, $urandom_range(1) ? 65535 : $urandom_range(0, 65535),
                          $urandom_range(3), 1'($urandom_range(1)));
                if (sent == 0 || $urandom_range(5) == 0)
                begin
                    // Stall the receiver so the block fills up
                    recv_hold = 1'b1;
                end
                queue_frame(w, h, 1);
                sent += w * h + w + 1;
                wait_idle();
            end
        end

        // A height above the maximum is written, then replaced by 2; width zero counts as one
        set_frame(0, 8191, 255, MODE_BLUR, 0);
        write_reg(REG_HEIGHT, 2);
        queue_frame(1, 2, 0);
        wait_idle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
